### rtl/baa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package baa_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CLEAR,
		ST_SCAN,
		ST_COMMIT,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam logic [1:0] MODE_CLAIM = 2'd0;
	localparam logic [1:0] MODE_DONE  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] OUTCOME_NONE    = 2'd0;
	localparam logic [1:0] OUTCOME_APPLIED = 2'd1;
	localparam logic [1:0] OUTCOME_STALE   = 2'd2;

	localparam logic [1:0] CFG_NODE_ID    = 2'd0;
	localparam logic [1:0] CFG_NODE_INDEX = 2'd1;
	localparam logic [1:0] CFG_DWELL_TIME = 2'd2;

	localparam logic [7:0] NO_TASK = 8'hFF;
	localparam logic signed [15:0] LOWEST_SCORE = 16'sh8000;

	localparam int ROM_ROWS = 3;
	localparam int ROM_COLS = 12;

	localparam logic [6:0] SCORE_ROM [0:ROM_ROWS-1][0:ROM_COLS-1] = '{
		'{7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55, 7'd0, 7'd0, 7'd0},
		'{7'd93, 7'd96, 7'd88, 7'd82, 7'd78, 7'd72, 7'd66, 7'd62, 7'd58, 7'd0, 7'd0, 7'd0},
		'{7'd91, 7'd89, 7'd97, 7'd84, 7'd79, 7'd74, 7'd68, 7'd64, 7'd61, 7'd0, 7'd0, 7'd0}
	};

	// one candidate task as seen by the pick unit
	typedef struct packed {
		logic signed [15:0] mine;
		logic [7:0]         owner;
		logic signed [15:0] cur_bid;
		logic               blocked;
	} cand_t;

	function automatic logic signed [15:0] own_score(input logic [1:0] row,
		input logic [3:0] t);
		logic [1:0] r;
		logic signed [15:0] s;
		r = (row > 2'd2) ? 2'd2 : row;
		if (t >= 4'(ROM_COLS)) begin
			s = 16'sd0;
		end else begin
			s = $signed({9'd0, SCORE_ROM[r][t]});
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/bundle_auction_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                | payload
// item     | item_valid / item_stall  | mode, task_index, sender_id, claim_bid, time_now
// result   | result_valid / result_stall | executing_task, bundle_count, event_count,
//          |                          | claim_outcome, bundle_changed
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// an item without a rebuild passes the decide state, then the out state, where the result register loads
// a rebuild adds the clear state, up to BUNDLE_DEPTH scan and commit passes and the finish state,
// each scan feeding one task per cycle through the shared pick unit
// after reset the block runs the initial rebuild with item_stall high
// a result waiting under result_stall holds the next result in the out state until taken

module bundle_auction_allocator
	import baa_pkg::*;
#(
	parameter int TASK_COUNT   = 9,
	parameter int BUNDLE_DEPTH = 4,
	parameter int NODE_COUNT   = 3
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [7:0]         task_index,
	input  logic [7:0]         sender_id,
	input  logic signed [15:0] claim_bid,
	input  logic [31:0]        time_now,

	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         executing_task,
	output logic [3:0]         bundle_count,
	output logic [7:0]         event_count,
	output logic [1:0]         claim_outcome,
	output logic               bundle_changed,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int KW = (BUNDLE_DEPTH > 1) ? $clog2(BUNDLE_DEPTH) : 1;
	localparam int LW = $clog2(BUNDLE_DEPTH + 1);

	state_t state_q, state_d;
	logic   init_q;

	logic [7:0]  node_id_q;
	logic [1:0]  node_index_q;
	logic [15:0] dwell_q;

	logic [7:0]         win_id_q  [TASK_COUNT];
	logic signed [15:0] win_bid_q [TASK_COUNT];
	logic [TASK_COUNT-1:0] fin_q;
	logic [TASK_COUNT-1:0] picked_q;

	logic [7:0]  list_q [BUNDLE_DEPTH];
	logic [7:0]  prev_q [BUNDLE_DEPTH];
	logic [LW-1:0] len_q;
	logic [LW-1:0] prev_len_q;
	logic [7:0]  cur_task_q;
	logic [31:0] start_q;
	logic [7:0]  events_q;

	logic [1:0]         mode_q;
	logic [7:0]         task_q;
	logic [7:0]         sender_q;
	logic signed [15:0] bid_q;
	logic [31:0]        now_q;
	logic [TW-1:0]      t_q;
	logic [1:0]         outcome_q;
	logic               changed_q;

	logic        res_valid_q;
	logic [7:0]  res_task_q;
	logic [3:0]  res_count_q;
	logic [7:0]  res_events_q;
	logic [1:0]  res_outcome_q;
	logic        res_changed_q;

	logic               accept;
	logic               cfg_write;
	logic               res_load;
	logic [1:0]         row;
	logic               task_ok;
	logic               cur_ok;
	logic [TW-1:0]      rd_idx;
	logic [7:0]         rd_id;
	logic signed [15:0] rd_bid;
	logic               rd_fin;
	logic               claim_win;
	logic               in_bundle;
	logic [31:0]        start_eff;
	logic [31:0]        elapsed;
	logic               tick_fire;
	logic               bundle_diff;
	logic [LW-1:0]      len_next;
	cand_t              cand;
	logic               pu_clr;
	logic               pu_en;
	logic               pu_found;
	logic [TW-1:0]      pu_pick;
	logic signed [15:0] pick_score;

	always_comb begin
		row = (node_index_q >= 2'(NODE_COUNT)) ? 2'(NODE_COUNT - 1) : node_index_q;
		task_ok = task_q < 8'(TASK_COUNT);
		cur_ok  = cur_task_q < 8'(TASK_COUNT);
		case (state_q)
			ST_SCAN: rd_idx = t_q;
			default: rd_idx = (mode_q == MODE_TICK) ? cur_task_q[TW-1:0] : task_q[TW-1:0];
		endcase
		rd_id  = win_id_q[rd_idx];
		rd_bid = win_bid_q[rd_idx];
		rd_fin = fin_q[rd_idx];
		claim_win = (bid_q > rd_bid) || (bid_q == rd_bid && sender_q < rd_id);
		in_bundle = 1'b0;
		bundle_diff = (prev_len_q != len_q);
		for (int i = 0; i < BUNDLE_DEPTH; i++) begin
			if (LW'(i) < len_q && list_q[i] == task_q) begin
				in_bundle = 1'b1;
			end
			if (LW'(i) < len_q && prev_q[i] != list_q[i]) begin
				bundle_diff = 1'b1;
			end
		end
		start_eff = (cur_ok && start_q == 32'd0) ? now_q : start_q;
		elapsed   = now_q - start_eff;
		tick_fire = cur_ok && (elapsed >= {16'd0, dwell_q});
		len_next  = len_q + LW'(1);
		cand.mine    = own_score(row, 4'(t_q));
		cand.owner   = rd_id;
		cand.cur_bid = rd_bid;
		cand.blocked = rd_fin || picked_q[t_q];
		pick_score   = own_score(row, 4'(pu_pick));
	end

	baa_pick_unit #(
		.TW(TW)
	) u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (pu_clr),
		.en      (pu_en),
		.cand    (cand),
		.idx     (t_q),
		.node_id (node_id_q),
		.found   (pu_found),
		.pick    (pu_pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		cfg_ready  = 1'b0;
		res_load   = 1'b0;
		pu_clr     = 1'b0;
		pu_en      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cfg_ready  = 1'b1;
				if (item_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
				case (mode_q)
					MODE_CLAIM: begin
						if (task_ok && !rd_fin && claim_win &&
							node_id_q != sender_q && in_bundle) begin
							state_d = ST_CLEAR;
						end
					end
					MODE_DONE: begin
						if (task_ok && !rd_fin) begin
							state_d = ST_CLEAR;
						end
					end
					MODE_TICK: begin
						if (tick_fire) begin
							state_d = ST_CLEAR;
						end
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_CLEAR: begin
				pu_clr  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				pu_en = 1'b1;
				if (t_q == TW'(TASK_COUNT - 1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				pu_clr = 1'b1;
				if (pu_found && len_next < LW'(BUNDLE_DEPTH)) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = init_q ? ST_IDLE : ST_OUT;
			end
			ST_OUT: begin
				if (!res_valid_q || !result_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept    = item_valid && !item_stall;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= 1'b1;
			node_id_q    <= 8'd1;
			node_index_q <= 2'd0;
			dwell_q      <= 16'd1000;
			for (int i = 0; i < TASK_COUNT; i++) begin
				win_id_q[i]  <= 8'd0;
				win_bid_q[i] <= 16'sd0;
			end
			fin_q      <= '0;
			picked_q   <= '0;
			len_q      <= '0;
			prev_len_q <= '0;
			cur_task_q <= NO_TASK;
			start_q    <= 32'd0;
			events_q   <= 8'd0;
			t_q        <= '0;
			outcome_q  <= OUTCOME_NONE;
			changed_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_NODE_ID:    node_id_q    <= cfg_data[7:0];
					CFG_NODE_INDEX: node_index_q <= cfg_data[1:0];
					CFG_DWELL_TIME: dwell_q      <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				outcome_q <= OUTCOME_NONE;
				changed_q <= 1'b0;
			end
			case (state_q)
				ST_DECIDE: begin
					case (mode_q)
						MODE_CLAIM: begin
							if (task_ok && !rd_fin) begin
								if (claim_win) begin
									win_id_q[rd_idx]  <= sender_q;
									win_bid_q[rd_idx] <= bid_q;
									outcome_q <= OUTCOME_APPLIED;
								end else begin
									outcome_q <= OUTCOME_STALE;
								end
							end
						end
						MODE_DONE: begin
							if (task_ok && !rd_fin) begin
								fin_q[rd_idx]     <= 1'b1;
								win_id_q[rd_idx]  <= 8'd0;
								win_bid_q[rd_idx] <= 16'sd0;
								events_q <= events_q + 8'd1;
							end
						end
						MODE_TICK: begin
							if (cur_ok && start_q == 32'd0) begin
								start_q <= now_q;
							end
							if (tick_fire) begin
								fin_q[rd_idx]     <= 1'b1;
								win_id_q[rd_idx]  <= 8'd0;
								win_bid_q[rd_idx] <= 16'sd0;
								events_q <= events_q + 8'd1;
							end
						end
						default: ;
					endcase
				end
				ST_CLEAR: begin
					for (int i = 0; i < TASK_COUNT; i++) begin
						if (win_id_q[i] == node_id_q) begin
							win_id_q[i]  <= 8'd0;
							win_bid_q[i] <= 16'sd0;
						end
					end
					prev_len_q <= len_q;
					len_q      <= '0;
					picked_q   <= '0;
					t_q        <= '0;
				end
				ST_SCAN: begin
					t_q <= (t_q == TW'(TASK_COUNT - 1)) ? '0 : t_q + TW'(1);
				end
				ST_COMMIT: begin
					t_q <= '0;
					if (pu_found) begin
						len_q <= len_next;
						win_id_q[pu_pick]  <= node_id_q;
						win_bid_q[pu_pick] <= pick_score;
						picked_q[pu_pick]  <= 1'b1;
					end
				end
				ST_FINISH: begin
					init_q     <= 1'b0;
					cur_task_q <= (len_q != '0) ? list_q[0] : NO_TASK;
					if (bundle_diff) begin
						events_q  <= events_q + 8'd1;
						start_q   <= 32'd0;
						changed_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			task_q   <= task_index;
			sender_q <= sender_id;
			bid_q    <= claim_bid;
			now_q    <= time_now;
		end
		if (state_q == ST_CLEAR) begin
			for (int i = 0; i < BUNDLE_DEPTH; i++) begin
				prev_q[i] <= list_q[i];
			end
		end
		if (state_q == ST_COMMIT && pu_found) begin
			list_q[len_q[KW-1:0]] <= 8'(pu_pick);
		end
		if (res_load) begin
			res_task_q    <= cur_task_q;
			res_count_q   <= 4'(len_q);
			res_events_q  <= events_q;
			res_outcome_q <= outcome_q;
			res_changed_q <= changed_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign executing_task = res_task_q;
	assign bundle_count   = res_count_q;
	assign event_count    = res_events_q;
	assign claim_outcome  = res_outcome_q;
	assign bundle_changed = res_changed_q;

endmodule

`default_nettype wire

### rtl/baa_pick_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module baa_pick_unit
	import baa_pkg::*;
#(
	parameter int TW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          en,
	input  cand_t         cand,
	input  logic [TW-1:0] idx,
	input  logic [7:0]    node_id,
	output logic          found,
	output logic [TW-1:0] pick
);

	logic signed [15:0] best_q;
	logic               found_q;
	logic [TW-1:0]      pick_q;
	logic               eligible;
	logic               better;

	always_comb begin
		eligible = !cand.blocked &&
			(cand.owner == 8'd0 || cand.owner == node_id ||
			 $signed(cand.mine) > $signed(cand.cur_bid) ||
			 ($signed(cand.mine) == $signed(cand.cur_bid) && node_id < cand.owner));
		better = $signed(cand.mine) > best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= LOWEST_SCORE;
			found_q <= 1'b0;
		end else if (clr) begin
			best_q  <= LOWEST_SCORE;
			found_q <= 1'b0;
		end else if (en && eligible && better) begin
			best_q  <= $signed(cand.mine);
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && eligible && better) begin
			pick_q <= idx;
		end
	end

	assign found = found_q;
	assign pick  = pick_q;

endmodule

`default_nettype wire

### sim/bundle_auction_allocator_test.sv
`timescale 1ns / 1ps

module bundle_auction_allocator_test
	import baa_pkg::*;
();

	localparam int TASKS = 9;
	localparam int DEPTH = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam int SCORES [3][TASKS] = '{
		'{95, 90, 85, 80, 75, 70, 65, 60, 55},
		'{93, 96, 88, 82, 78, 72, 66, 62, 58},
		'{91, 89, 97, 84, 79, 74, 68, 64, 61}
	};

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         task_id;
		logic [7:0]         sender;
		logic signed [15:0] bid;
		logic [31:0]        now;
	} request_t;

	typedef struct packed {
		logic [7:0] run_task;
		logic [3:0] count;
		logic [7:0] events;
		logic [1:0] outcome;
		logic       changed;
	} status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         mode = MODE_CLAIM;
	logic [7:0]         task_index = '0;
	logic [7:0]         sender_id = '0;
	logic signed [15:0] claim_bid = '0;
	logic [31:0]        time_now = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [7:0]         executing_task;
	logic [3:0]         bundle_count;
	logic [7:0]         event_count;
	logic [1:0]         claim_outcome;
	logic               bundle_changed;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_NODE_ID;
	logic [15:0]        cfg_data = '0;

	// allocator model state
	logic [7:0]  my_id;
	logic [1:0]  my_row;
	logic [15:0] dwell_ms;
	logic [7:0]  owner [TASKS];
	int          owner_score [TASKS];
	logic        done_flag [TASKS];
	logic [7:0]  bundle [DEPTH];
	logic [3:0]  bundle_size;
	logic [7:0]  running_task;
	logic [31:0] started_at;
	logic [7:0]  event_total;

	request_t pending_requests [$];
	status_t  expected_status [$];
	int       mismatches = 0;
	int       cycles = 0;
	int       send_gap_pct = 0;
	int       stall_pct = 0;
	logic [31:0] ms_clock = 32'd3000;

	bundle_auction_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.mode(mode),
		.task_index(task_index),
		.sender_id(sender_id),
		.claim_bid(claim_bid),
		.time_now(time_now),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.executing_task(executing_task),
		.bundle_count(bundle_count),
		.event_count(event_count),
		.claim_outcome(claim_outcome),
		.bundle_changed(bundle_changed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int score_of(int t);
		int row;
		row = (my_row >= 2'd3) ? 2 : int'(my_row);
		return SCORES[row][t];
	endfunction

	function automatic logic held(int t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			if (i < bundle_size && bundle[i] == t) hit = 1'b1;
		return hit;
	endfunction

	// greedy refill of the bundle from the tasks this node can still win
	function automatic logic rebuild_bundle();
		logic [7:0] prev [DEPTH];
		logic [3:0] prev_len;
		logic changed;
		int best;
		int pick;
		int mine;
		prev = bundle;
		prev_len = bundle_size;
		for (int t = 0; t < TASKS; t++)
			if (owner[t] == my_id) begin
				owner[t] = '0;
				owner_score[t] = 0;
			end
		bundle_size = '0;
		for (int k = 0; k < DEPTH; k++) begin
			best = -32768;
			pick = -1;
			for (int t = 0; t < TASKS; t++) begin
				mine = score_of(t);
				if (!done_flag[t] && !held(t) && mine > best &&
					(owner[t] == 8'd0 || owner[t] == my_id || mine > owner_score[t] ||
					(mine == owner_score[t] && my_id < owner[t]))) begin
					best = mine;
					pick = t;
				end
			end
			if (pick >= 0) begin
				bundle[bundle_size] = 8'(pick);
				bundle_size = bundle_size + 4'd1;
				owner[pick] = my_id;
				owner_score[pick] = best;
			end
		end
		running_task = (bundle_size != 4'd0) ? bundle[0] : NO_TASK;
		changed = (prev_len != bundle_size);
		for (int i = 0; i < DEPTH; i++)
			if (i < bundle_size && prev[i] != bundle[i]) changed = 1'b1;
		if (changed) begin
			event_total = event_total + 8'd1;
			started_at = '0;
		end
		return changed;
	endfunction

	function automatic logic finish_task(int t);
		done_flag[t] = 1'b1;
		owner[t] = '0;
		owner_score[t] = 0;
		event_total = event_total + 8'd1;
		return rebuild_bundle();
	endfunction

	function automatic void reset_model();
		my_id = 8'd1;
		my_row = 2'd0;
		dwell_ms = 16'd1000;
		for (int t = 0; t < TASKS; t++) begin
			owner[t] = '0;
			owner_score[t] = 0;
			done_flag[t] = 1'b0;
		end
		for (int i = 0; i < DEPTH; i++)
			bundle[i] = '0;
		bundle_size = '0;
		running_task = NO_TASK;
		started_at = '0;
		event_total = '0;
		void'(rebuild_bundle());
	endfunction

	function automatic status_t apply_request(request_t r);
		status_t s;
		int t;
		int bid;
		s.outcome = OUTCOME_NONE;
		s.changed = 1'b0;
		t = int'(r.task_id);
		bid = int'(r.bid);
		case (r.mode)
			MODE_CLAIM: begin
				if (t < TASKS && !done_flag[t]) begin
					if (bid > owner_score[t] ||
						(bid == owner_score[t] && r.sender < owner[t])) begin
						owner[t] = r.sender;
						owner_score[t] = bid;
						s.outcome = OUTCOME_APPLIED;
						if (r.sender != my_id && held(t)) s.changed = rebuild_bundle();
					end else begin
						s.outcome = OUTCOME_STALE;
					end
				end
			end
			MODE_DONE: begin
				if (t < TASKS && !done_flag[t]) s.changed = finish_task(t);
			end
			MODE_TICK: begin
				if (running_task != NO_TASK && started_at == 32'd0) started_at = r.now;
				if (running_task != NO_TASK && running_task < TASKS &&
					r.now - started_at >= {16'd0, dwell_ms})
					s.changed = finish_task(int'(running_task));
			end
			default: ;
		endcase
		s.run_task = running_task;
		s.count = bundle_size;
		s.events = event_total;
		return s;
	endfunction

	function automatic void push_request(logic [1:0] m, logic [7:0] t, logic [7:0] snd,
		logic signed [15:0] b, logic [31:0] n);
		request_t r;
		r.mode = m;
		r.task_id = t;
		r.sender = snd;
		r.bid = b;
		r.now = n;
		pending_requests.push_back(r);
	endfunction

	// mostly claims on real tasks with bids near the score range
	function automatic void queue_random(int count, int tick_pct, logic wild_time);
		request_t r;
		int roll;
		int pick;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			r.now = ms_clock;
			ms_clock = ms_clock + $urandom_range(3);
			if (wild_time && $urandom_range(3) == 0) r.now = $urandom;
			r.task_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(TASKS - 1));
			pick = $urandom_range(99);
			if (pick < 35)
				r.sender = my_id;
			else if (pick < 80)
				r.sender = 8'($urandom_range(4));
			else
				r.sender = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 65) begin
				r.bid = 16'($urandom_range(110, 30));
			end else if (pick < 80) begin
				r.bid = 16'(int'($urandom_range(80)) - 40);
			end else if (pick < 92) begin
				r.bid = 16'($urandom);
			end else begin
				case ($urandom_range(3))
					0: r.bid = 16'sh8000;
					1: r.bid = 16'sh7FFF;
					2: r.bid = -16'sd1;
					default: r.bid = 16'sd0;
				endcase
			end
			if (roll < tick_pct) begin
				r.mode = MODE_TICK;
			end else if (roll < tick_pct + 6) begin
				r.mode = MODE_DONE;
				r.task_id = 8'($urandom_range(255, TASKS));
			end else if (roll < tick_pct + 8) begin
				r.mode = MODE_RESERVED;
			end else begin
				r.mode = MODE_CLAIM;
			end
			pending_requests.push_back(r);
		end
	endfunction

	task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NODE_ID: my_id = data[7:0];
			CFG_NODE_INDEX: my_row = data[1:0];
			CFG_DWELL_TIME: dwell_ms = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [7:0] id, input logic [1:0] row,
		input logic [15:0] dwell);
		write_register(CFG_NODE_ID, {8'($urandom), id});
		write_register(CFG_NODE_INDEX, {14'($urandom), row});
		write_register(CFG_DWELL_TIME, dwell);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || item_valid || expected_status.size() != 0);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bundle_auction_allocator verification failed");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		request_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				r.mode = mode;
				r.task_id = task_index;
				r.sender = sender_id;
				r.bid = claim_bid;
				r.now = time_now;
				expected_status.push_back(apply_request(r));
			end
			if (!item_valid || !item_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					r = pending_requests.pop_front();
					item_valid <= 1'b1;
					mode <= r.mode;
					task_index <= r.task_id;
					sender_id <= r.sender;
					claim_bid <= r.bid;
					time_now <= r.now;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// status monitor
	always @(posedge clk) begin
		status_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_status.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("executing_task", want.run_task, executing_task);
					check_field("bundle_count", 8'(want.count), 8'(bundle_count));
					check_field("event_count", want.events, event_count);
					check_field("claim_outcome", 8'(want.outcome), 8'(claim_outcome));
					check_field("bundle_changed", 8'(want.changed), 8'(bundle_changed));
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		reset_model();

		// dwell timing, start at time zero
		push_request(MODE_TICK, 8'd0, 8'd0, 16'sd0, 32'd0);
		push_request(MODE_TICK, 8'd0, 8'd0, 16'sd0, 32'd5);
		push_request(MODE_TICK, 8'd0, 8'd0, 16'sd0, 32'd1004);
		push_request(MODE_TICK, 8'd0, 8'd0, 16'sd0, 32'd1005);
		// unowned task and tie rules
		push_request(MODE_CLAIM, 8'd8, 8'd0, 16'sd0, 32'd0);
		push_request(MODE_CLAIM, 8'd8, 8'd200, 16'sd1, 32'd0);
		push_request(MODE_CLAIM, 8'd8, 8'd100, 16'sd1, 32'd0);
		push_request(MODE_CLAIM, 8'd8, 8'd150, 16'sd1, 32'd0);
		push_request(MODE_CLAIM, 8'd7, 8'd255, 16'sh8000, 32'd0);
		// outbid on a bundled task, then a claim from this node
		push_request(MODE_CLAIM, 8'd1, 8'd2, 16'sh7FFF, 32'd0);
		push_request(MODE_CLAIM, 8'd2, 8'd1, 16'sd200, 32'd0);
		// out of range, finished, reserved mode
		push_request(MODE_CLAIM, 8'd9, 8'd3, 16'sd50, 32'd0);
		push_request(MODE_CLAIM, 8'd255, 8'd255, -16'sd1, 32'hFFFF_FFFF);
		push_request(MODE_DONE, 8'd255, 8'd0, 16'sd0, 32'd0);
		push_request(MODE_DONE, 8'd2, 8'd0, 16'sd0, 32'd0);
		push_request(MODE_DONE, 8'd2, 8'd0, 16'sd0, 32'd0);
		push_request(MODE_CLAIM, 8'd2, 8'd3, 16'sd500, 32'd0);
		push_request(MODE_RESERVED, 8'd3, 8'd255, 16'sh7FFF, 32'hFFFF_FFFF);
		push_request(MODE_TICK, 8'd0, 8'd0, 16'sd0, 32'hFFFF_FFFF);
		push_request(MODE_CLAIM, 8'd5, 8'd0, 16'sd96, 32'd0);
		queue_random(290, 10, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		set_registers(8'd255, 2'd2, 16'd60000);
		send_gap_pct = 65;
		stall_pct = 0;
		queue_random(145, 10, 1'b0);
		push_request(MODE_DONE, 8'($urandom_range(TASKS - 1)), 8'd0, 16'sd0, ms_clock);
		queue_random(145, 10, 1'b0);
		drain();

		// node id zero, row past the table
		set_registers(8'd0, 2'd3, 16'hFFFF);
		send_gap_pct = 0;
		stall_pct = 65;
		queue_random(290, 10, 1'b0);
		drain();

		// sender holds off until everything is back
		set_registers(8'd2, 2'd1, 16'd1);
		send_gap_pct = 26;
		stall_pct = 26;
		queue_random(145, 1, 1'b0);
		drain();
		queue_random(145, 1, 1'b0);
		drain();

		set_registers(8'd3, 2'd0, 16'd0);
		send_gap_pct = 0;
		stall_pct = 0;
		queue_random(290, 1, 1'b0);
		drain();

		set_registers(8'($urandom_range(4, 1)), 2'($urandom_range(3)), 16'd500);
		send_gap_pct = 65;
		stall_pct = 0;
		queue_random(290, 5, 1'b1);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("bundle_auction_allocator verification clean");
		end else begin
			$display("bundle_auction_allocator verification failed");
		end
		$finish;
	end

endmodule
